### rtl/pdmg_pkg.sv
// Package for the per-device message guard: request and result structs,
// the table entry layout, decision and register codes, divider handshake types.
// No dependencies.
package pdmg_pkg;

    // Default table depth.
    localparam int TABLE_DEPTH_DEF = 16;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DUP_WINDOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFILL       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIKE_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_QUARANTINE   = 3'd4;

    // Decision codes.
    localparam logic [2:0] DEC_ALLOW   = 3'd0;
    localparam logic [2:0] DEC_DUP     = 3'd1;
    localparam logic [2:0] DEC_RATE    = 3'd2;
    localparam logic [2:0] DEC_QUAR    = 3'd3;
    localparam logic [2:0] DEC_INVALID = 3'd4;

    // Strike counter saturation value.
    localparam logic [7:0] STRIKE_MAX = 8'hFF;

    // Divider operand width.
    localparam int DIV_W = 32;

    typedef struct packed {
        logic [31:0] key_hash;
        logic        key_present;
        logic [31:0] payload_fingerprint;
        logic [31:0] now_ms;
    } msg_t;

    typedef struct packed {
        logic [2:0] decision;
        logic       evicted;
        logic [3:0] slot_used;
        logic [7:0] tokens_left;
    } res_t;

    // One table entry as held in the entry memory.
    typedef struct packed {
        logic [31:0] key;
        logic [7:0]  tokens;
        logic [7:0]  strikes;
        logic        has_accepted;
        logic [31:0] last_print;
        logic [31:0] last_seen;
        logic [31:0] last_refill;
        logic [31:0] last_accept_time;
        logic [31:0] quarantine_end;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Divider request and response.
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DIV_W-1:0] rem;
    } div_rsp_t;

endpackage

### rtl/pdmg_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
module pdmg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/pdmg_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pdmg_pkg for the request and response types.
module pdmg_div (
    input  logic               clk,
    input  logic               rst_n,
    input  pdmg_pkg::div_req_t req,
    output pdmg_pkg::div_rsp_t rsp
);
    import pdmg_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;

    // One trial subtraction per cycle.
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIV_W-1]};
        diff      = shifted - {1'b0, dsr_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[DIV_W])
            begin
                rem_next = diff[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            dsr_reg  <= dsr_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

### rtl/per_device_message_guard_core.sv
// Per-device message guard: token bucket, duplicate filter and quarantine per device.
// Path: a request is accepted, scanned against the table through the entry memory read
// port, checked for quarantine, refilled through the divider, decided and written back,
// and its result is registered; a quarantined device skips the divider, refill and
// decision, and an invalid request goes straight to the output register.
// Throughput: one request at a time; the next is taken after the result is registered,
// and a finished result waits while the previous one has not been taken.
// Reset: all entries invalid, registers at their defaults; no clearing pass is needed.
// Depends on pdmg_pkg, pdmg_ram and pdmg_div.
module per_device_message_guard_core #(
    parameter int TABLE_DEPTH = pdmg_pkg::TABLE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               msg_valid,
    output logic                               msg_ready,
    input  pdmg_pkg::msg_t                     msg,
    output logic                               res_valid,
    input  logic                               res_ready,
    output pdmg_pkg::res_t                     res,
    input  logic                               cfg_wr_en,
    input  logic [pdmg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pdmg_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import pdmg_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_DIV,
        S_REFILL,
        S_DECIDE,
        S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    msg_t                   msg_reg, msg_next;
    logic [CW-1:0]          scan_cnt_reg, scan_cnt_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]          cmp_idx_reg, cmp_idx_next;
    logic                   hit_reg, hit_next;
    logic                   free_found_reg, free_found_next;
    logic [IW-1:0]          free_idx_reg, free_idx_next;
    logic [IW-1:0]          old_idx_reg, old_idx_next;
    logic [31:0]            old_age_reg, old_age_next;
    entry_t                 ent_reg, ent_next;
    logic [IW-1:0]          slot_reg, slot_next;
    logic                   evicted_reg, evicted_next;
    res_t                   pend_reg, pend_next;
    res_t                   res_reg, res_next;
    logic                   res_valid_reg, res_valid_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [31:0]            dup_win_reg, dup_win_next;
    logic [31:0]            refill_reg, refill_next;
    logic [7:0]             burst_reg, burst_next;
    logic [7:0]             limit_reg, limit_next;
    logic [31:0]            quar_reg, quar_next;

    // Memory and divider hookup.
    logic                   ram_we;
    logic                   ram_re;
    logic [IW-1:0]          ram_raddr;
    entry_t                 ram_wdata;
    logic [ENTRY_W-1:0]     ram_rdata;
    div_req_t               div_req;
    div_rsp_t               div_rsp;

    // Scratch values for the combinational update.
    entry_t                 e;
    logic                   h;
    logic                   ff;
    logic [IW-1:0]          fi;
    logic [IW-1:0]          oi;
    logic [31:0]            oa;
    logic [31:0]            age;
    logic [31:0]            qdiff;
    logic                   quar_now;
    logic [31:0]            elapsed;
    logic [32:0]            tok_sum;
    logic [7:0]             strikes_inc;
    logic                   is_dup;

    pdmg_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (IW)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pdmg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Read addresses walk the table during the scan.
    assign ram_re    = (state_reg == S_SCAN) && (scan_cnt_reg < CW'(TABLE_DEPTH));
    assign ram_raddr = scan_cnt_reg[IW-1:0];

    // Next-state and datapath logic.
    always_comb
    begin
        state_next      = state_reg;
        msg_next        = msg_reg;
        scan_cnt_next   = scan_cnt_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        hit_next        = hit_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        old_idx_next    = old_idx_reg;
        old_age_next    = old_age_reg;
        ent_next        = ent_reg;
        slot_next       = slot_reg;
        evicted_next    = evicted_reg;
        pend_next       = pend_reg;
        res_next        = res_reg;
        res_valid_next  = res_valid_reg && !res_ready;
        valid_next      = valid_reg;
        dup_win_next    = dup_win_reg;
        refill_next     = refill_reg;
        burst_next      = burst_reg;
        limit_next      = limit_reg;
        quar_next       = quar_reg;
        ram_we          = 1'b0;
        ram_wdata       = ent_reg;
        div_req.start   = 1'b0;
        div_req.dividend = msg_reg.now_ms - ent_reg.last_refill;
        div_req.divisor = refill_reg;

        e           = ent_reg;
        h           = hit_reg;
        ff          = free_found_reg;
        fi          = free_idx_reg;
        oi          = old_idx_reg;
        oa          = old_age_reg;
        age         = '0;
        qdiff       = ent_reg.quarantine_end - msg_reg.now_ms;
        quar_now    = (ent_reg.quarantine_end != '0) && (qdiff != '0) && !qdiff[31];
        elapsed     = msg_reg.now_ms - ent_reg.last_refill;
        tok_sum     = {25'b0, ent_reg.tokens} + {1'b0, div_rsp.quot};
        strikes_inc = (ent_reg.strikes < STRIKE_MAX) ? ent_reg.strikes + 8'd1
                                                     : ent_reg.strikes;
        is_dup      = ent_reg.has_accepted
                      && (ent_reg.last_print == msg_reg.payload_fingerprint)
                      && ((msg_reg.now_ms - ent_reg.last_accept_time) <= dup_win_reg);

        // Configuration writes; zero is raised to one where the register needs it.
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_DUP_WINDOW:   dup_win_next = cfg_wdata;
                CFG_REFILL:       refill_next  = (cfg_wdata == '0) ? 32'd1 : cfg_wdata;
                CFG_BURST:        burst_next   = (cfg_wdata[7:0] == '0) ? 8'd1
                                                                      : cfg_wdata[7:0];
                CFG_STRIKE_LIMIT: limit_next   = (cfg_wdata[7:0] == '0) ? 8'd1
                                                                      : cfg_wdata[7:0];
                CFG_QUARANTINE:   quar_next    = (cfg_wdata == '0) ? 32'd1 : cfg_wdata;
                default:          ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (msg_valid)
                begin
                    msg_next = msg;
                    if (!msg.key_present || (msg.payload_fingerprint == '0))
                    begin
                        pend_next   = '0;
                        pend_next.decision = DEC_INVALID;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        scan_cnt_next   = '0;
                        hit_next        = 1'b0;
                        free_found_next = 1'b0;
                        free_idx_next   = '0;
                        old_idx_next    = '0;
                        old_age_next    = '0;
                        state_next      = S_SCAN;
                    end
                end
            end

            // Issue one read per cycle and compare the entry read last cycle.
            S_SCAN:
            begin
                if (scan_cnt_reg < CW'(TABLE_DEPTH))
                begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = scan_cnt_reg[IW-1:0];
                end
                if (cmp_vld_reg)
                begin
                    e   = entry_t'(ram_rdata);
                    age = msg_reg.now_ms - e.last_seen;
                    if (valid_reg[cmp_idx_reg])
                    begin
                        if (!h && (e.key == msg_reg.key_hash))
                        begin
                            h        = 1'b1;
                            ent_next = e;
                            slot_next = cmp_idx_reg;
                        end
                        else if (age >= oa)
                        begin
                            oa = age;
                            oi = cmp_idx_reg;
                        end
                    end
                    else if (!ff)
                    begin
                        ff = 1'b1;
                        fi = cmp_idx_reg;
                    end
                    hit_next        = h;
                    free_found_next = ff;
                    free_idx_next   = fi;
                    old_idx_next    = oi;
                    old_age_next    = oa;
                    // Last entry compared: pick the slot and start evaluation.
                    if (cmp_idx_reg == IW'(TABLE_DEPTH - 1))
                    begin
                        evicted_next = !h && !ff;
                        if (!h)
                        begin
                            slot_next = ff ? fi : oi;
                            ent_next  = '0;
                            ent_next.key         = msg_reg.key_hash;
                            ent_next.tokens      = burst_reg;
                            ent_next.last_seen   = msg_reg.now_ms;
                            ent_next.last_refill = msg_reg.now_ms;
                        end
                        state_next = S_EVAL;
                    end
                end
            end

            // Quarantine check; otherwise start the refill division.
            S_EVAL:
            begin
                e = ent_reg;
                e.last_seen = msg_reg.now_ms;
                if (quar_now)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = e;
                    valid_next[slot_reg] = 1'b1;
                    pend_next.decision    = DEC_QUAR;
                    pend_next.evicted     = evicted_reg;
                    pend_next.slot_used   = 4'(slot_reg);
                    pend_next.tokens_left = e.tokens;
                    state_next = S_DONE;
                end
                else
                begin
                    if (e.quarantine_end != '0)
                    begin
                        e.quarantine_end = '0;
                        e.strikes        = '0;
                    end
                    ent_next      = e;
                    div_req.start = 1'b1;
                    state_next    = S_DIV;
                end
            end

            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_REFILL;
                end
            end

            // Add regained tokens, saturating at capacity.
            S_REFILL:
            begin
                if (div_rsp.quot != '0)
                begin
                    ent_next.tokens = (tok_sum > {25'b0, burst_reg}) ? burst_reg
                                                                     : tok_sum[7:0];
                    ent_next.last_refill = ent_reg.last_refill + (elapsed - div_rsp.rem);
                end
                state_next = S_DECIDE;
            end

            // Final decision and write-back.
            S_DECIDE:
            begin
                e = ent_reg;
                if (is_dup)
                begin
                    pend_next.decision = DEC_DUP;
                end
                else if (e.tokens == '0)
                begin
                    e.strikes = strikes_inc;
                    if (strikes_inc >= limit_reg)
                    begin
                        e.quarantine_end   = msg_reg.now_ms + quar_reg;
                        pend_next.decision = DEC_QUAR;
                    end
                    else
                    begin
                        pend_next.decision = DEC_RATE;
                    end
                end
                else
                begin
                    e.tokens           = e.tokens - 8'd1;
                    e.strikes          = '0;
                    e.has_accepted     = 1'b1;
                    e.last_print       = msg_reg.payload_fingerprint;
                    e.last_accept_time = msg_reg.now_ms;
                    pend_next.decision = DEC_ALLOW;
                end
                ram_we    = 1'b1;
                ram_wdata = e;
                ent_next  = e;
                valid_next[slot_reg]  = 1'b1;
                pend_next.evicted     = evicted_reg;
                pend_next.slot_used   = 4'(slot_reg);
                pend_next.tokens_left = e.tokens;
                state_next = S_DONE;
            end

            // Hand the result to the output register once it is free.
            S_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_next       = pend_reg;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, registered outputs and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            msg_reg        <= '0;
            scan_cnt_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            old_idx_reg    <= '0;
            old_age_reg    <= '0;
            ent_reg        <= '0;
            slot_reg       <= '0;
            evicted_reg    <= 1'b0;
            pend_reg       <= '0;
            res_reg        <= '0;
            res_valid_reg  <= 1'b0;
            valid_reg      <= '0;
            dup_win_reg    <= 32'd3000;
            refill_reg     <= 32'd1000;
            burst_reg      <= 8'd5;
            limit_reg      <= 8'd3;
            quar_reg       <= 32'd30000;
        end
        else
        begin
            state_reg      <= state_next;
            msg_reg        <= msg_next;
            scan_cnt_reg   <= scan_cnt_next;
            cmp_vld_reg    <= cmp_vld_next;
            cmp_idx_reg    <= cmp_idx_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            old_idx_reg    <= old_idx_next;
            old_age_reg    <= old_age_next;
            ent_reg        <= ent_next;
            slot_reg       <= slot_next;
            evicted_reg    <= evicted_next;
            pend_reg       <= pend_next;
            res_reg        <= res_next;
            res_valid_reg  <= res_valid_next;
            valid_reg      <= valid_next;
            dup_win_reg    <= dup_win_next;
            refill_reg     <= refill_next;
            burst_reg      <= burst_next;
            limit_reg      <= limit_next;
            quar_reg       <= quar_next;
        end
    end

    assign msg_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // An invalid request reports no slot, no eviction and no tokens.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.decision == DEC_INVALID) |->
            !res.evicted && (res.slot_used == '0) && (res.tokens_left == '0))
        else $error("invalid request reported table fields");

    // Eviction only happens when every entry is in use.
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.evicted |-> (&valid_reg))
        else $error("eviction with a free entry");

    // The divider is idle whenever a new request can be taken.
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        msg_ready |-> !div_rsp.busy)
        else $error("divider busy while idle");

    // The entry memory is never written while a request may be accepted.
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !msg_ready)
        else $error("entry write while idle");

endmodule
